// ----- sv/nbc_pkg.sv -----
// Package: shared constants, codes and types for the nearest-box selector.
package nbc_pkg;

	localparam int DEF_COORD_BITS = 12;
	localparam int SCREEN_BITS    = 13;
	localparam int CENTER_BITS    = 12;
	localparam int OFFSET_BITS    = 16;
	localparam int CLASS_BITS     = 8;
	localparam int CFG_IDX_BITS   = 2;
	localparam int CFG_DATA_BITS  = 16;
	localparam int QUEUE_DEPTH    = 4;

	localparam logic [SCREEN_BITS-1:0] SCREEN_W_RST = 13'd640;
	localparam logic [SCREEN_BITS-1:0] SCREEN_H_RST = 13'd640;
	localparam logic [OFFSET_BITS-1:0] OFFSET_RST   = 16'd62259;

	localparam logic [CLASS_BITS-1:0] CLASS_HEAD   = 8'd7;
	localparam logic [CLASS_BITS-1:0] CLASS_BODY_0 = 8'd0;
	localparam logic [CLASS_BITS-1:0] CLASS_BODY_1 = 8'd1;
	localparam logic [CLASS_BITS-1:0] CLASS_BODY_5 = 8'd5;
	localparam logic [CLASS_BITS-1:0] CLASS_BODY_6 = 8'd6;

	localparam logic ACT_ADD    = 1'b0;
	localparam logic ACT_FINISH = 1'b1;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_SCREEN_WIDTH  = 2'd0,
		REG_SCREEN_HEIGHT = 2'd1,
		REG_BODY_OFFSET   = 2'd2
	} nbc_reg_t;

	typedef enum logic [1:0] {
		KIND_HEAD   = 2'd0,
		KIND_BODY   = 2'd1,
		KIND_FINISH = 2'd2
	} nbc_kind_t;

	typedef struct packed {
		logic [CENTER_BITS-1:0] cx;
		logic [CENTER_BITS-1:0] cy;
		logic [OFFSET_BITS-1:0] body_offset;
	} nbc_cfg_t;

endpackage

// ----- sv/nbc_if.sv -----
// Interfaces: box input channel and selection result channel.
interface nbc_in_if #(parameter int COORD_BITS = 12);
	logic                  valid;
	logic                  ready;
	logic                  action;
	logic [COORD_BITS-1:0] box_x;
	logic [COORD_BITS-1:0] box_y;
	logic [COORD_BITS-1:0] box_w;
	logic [COORD_BITS-1:0] box_h;
	logic [7:0]            class_id;

	modport source (output valid, action, box_x, box_y, box_w, box_h, class_id, input ready);
	modport sink   (input valid, action, box_x, box_y, box_w, box_h, class_id, output ready);
endinterface

interface nbc_out_if #(parameter int COORD_BITS = 12);
	logic                  valid;
	logic                  ready;
	logic                  found;
	logic                  is_head;
	logic [COORD_BITS-1:0] sel_x;
	logic [COORD_BITS-1:0] sel_y;
	logic [COORD_BITS-1:0] sel_w;
	logic [COORD_BITS-1:0] sel_h;
	logic [7:0]            sel_class;

	modport source (output valid, found, is_head, sel_x, sel_y, sel_w, sel_h, sel_class,
		input ready);
	modport sink   (input valid, found, is_head, sel_x, sel_y, sel_w, sel_h, sel_class,
		output ready);
endinterface

// ----- sv/nbc_front.sv -----
// Front end: accepts items, classifies them and computes squared distances.
module nbc_front import nbc_pkg::*; #(
	parameter int COORD_BITS = DEF_COORD_BITS,
	parameter int DIST_BITS  = 27,
	parameter int ENTRY_BITS = 2 + 27 + 4 * 12 + 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	nbc_in_if.sink                in_ch,
	input  nbc_cfg_t              cfg,
	output logic                  q_push,
	input  logic                  q_ready,
	output logic [ENTRY_BITS-1:0] q_data
);

	localparam int PW = COORD_BITS + OFFSET_BITS;
	localparam int DW = (DIST_BITS - 1) / 2;

	logic advance;
	logic keep, acc;
	nbc_kind_t kind_in;

	logic                  valid_s1, valid_s2, valid_s3;
	nbc_kind_t             kind_s1, kind_s2, kind_s3;
	logic [COORD_BITS-1:0] x_s1, y_s1, w_s1, h_s1;
	logic [COORD_BITS-1:0] x_s2, y_s2, w_s2, h_s2;
	logic [COORD_BITS-1:0] x_s3, y_s3, w_s3, h_s3;
	logic [7:0]            cls_s1, cls_s2, cls_s3;
	logic [PW-1:0]         prod_s1;
	logic [DW-1:0]         dx_s2, dy_s2;
	logic [2*DW-1:0]       dxsq_s3, dysq_s3;

	logic [COORD_BITS:0] px, py;
	logic [DW-1:0]       pxe, pye, cxe, cye;
	logic [DIST_BITS-1:0] d2;

	assign advance     = !valid_s3 || q_ready;
	assign in_ch.ready = advance;
	assign acc         = in_ch.valid && advance;

	always_comb begin
		keep    = 1'b1;
		kind_in = KIND_FINISH;
		if (in_ch.action == ACT_ADD) begin
			if (in_ch.class_id == CLASS_HEAD) begin
				kind_in = KIND_HEAD;
			end else if (in_ch.class_id inside {CLASS_BODY_0, CLASS_BODY_1,
					CLASS_BODY_5, CLASS_BODY_6}) begin
				kind_in = KIND_BODY;
			end else begin
				keep = 1'b0;
			end
		end
	end

	always_comb begin
		px = {1'b0, x_s1} + {2'b00, w_s1[COORD_BITS-1:1]};
		if (kind_s1 == KIND_HEAD) begin
			py = {1'b0, y_s1} + {2'b00, h_s1[COORD_BITS-1:1]};
		end else begin
			py = {1'b0, y_s1} + {1'b0, prod_s1[PW-1:OFFSET_BITS]};
		end
		pxe = DW'(px);
		pye = DW'(py);
		cxe = DW'(cfg.cx);
		cye = DW'(cfg.cy);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= acc && keep;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			kind_s1 <= kind_in;
			x_s1    <= in_ch.box_x;
			y_s1    <= in_ch.box_y;
			w_s1    <= in_ch.box_w;
			h_s1    <= in_ch.box_h;
			cls_s1  <= in_ch.class_id;
			prod_s1 <= PW'(in_ch.box_h) * PW'(cfg.body_offset);

			kind_s2 <= kind_s1;
			x_s2    <= x_s1;
			y_s2    <= y_s1;
			w_s2    <= w_s1;
			h_s2    <= h_s1;
			cls_s2  <= cls_s1;
			dx_s2   <= (pxe > cxe) ? pxe - cxe : cxe - pxe;
			dy_s2   <= (pye > cye) ? pye - cye : cye - pye;

			kind_s3 <= kind_s2;
			x_s3    <= x_s2;
			y_s3    <= y_s2;
			w_s3    <= w_s2;
			h_s3    <= h_s2;
			cls_s3  <= cls_s2;
			dxsq_s3 <= (2*DW)'(dx_s2) * (2*DW)'(dx_s2);
			dysq_s3 <= (2*DW)'(dy_s2) * (2*DW)'(dy_s2);
		end
	end

	assign d2     = DIST_BITS'(dxsq_s3) + DIST_BITS'(dysq_s3);
	assign q_push = valid_s3;
	assign q_data = {kind_s3, d2, x_s3, y_s3, w_s3, h_s3, cls_s3};

endmodule

// ----- sv/nbc_fifo.sv -----
// Small register queue between the front and back ends.
module nbc_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push, do_pop;

	assign push_ready = count_q != CW'(DEPTH);
	assign pop_valid  = count_q != '0;
	assign do_push    = push && push_ready;
	assign do_pop     = pop && pop_valid;
	assign pop_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ----- sv/nbc_back.sv -----
// Back end: running head/body minima and the result register.
module nbc_back import nbc_pkg::*; #(
	parameter int COORD_BITS = DEF_COORD_BITS,
	parameter int DIST_BITS  = 27,
	parameter int ENTRY_BITS = 2 + 27 + 4 * 12 + 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_valid,
	output logic                  q_pop,
	input  logic [ENTRY_BITS-1:0] q_data,
	nbc_out_if.source             out_ch
);

	localparam int BOX_BITS = 4 * COORD_BITS + CLASS_BITS;

	nbc_kind_t            kind;
	logic [DIST_BITS-1:0] d2;
	logic [BOX_BITS-1:0]  box;

	logic                 head_seen_q, body_seen_q;
	logic [DIST_BITS-1:0] head_dist_q, body_dist_q;
	logic [BOX_BITS-1:0]  head_box_q, body_box_q;

	logic                 out_valid_q, found_q, is_head_q;
	logic [BOX_BITS-1:0]  sel_q;
	logic                 out_free;

	assign kind     = nbc_kind_t'(q_data[ENTRY_BITS-1 -: 2]);
	assign d2       = q_data[BOX_BITS +: DIST_BITS];
	assign box      = q_data[BOX_BITS-1:0];
	assign out_free = !out_valid_q || out_ch.ready;
	assign q_pop    = q_valid && (kind != KIND_FINISH || out_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_seen_q <= 1'b0;
			body_seen_q <= 1'b0;
			head_dist_q <= '1;
			body_dist_q <= '1;
			head_box_q  <= '0;
			body_box_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop && kind == KIND_FINISH) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			if (q_pop) begin
				case (kind)
					KIND_HEAD: begin
						if (!head_seen_q || d2 < head_dist_q) begin
							head_seen_q <= 1'b1;
							head_dist_q <= d2;
							head_box_q  <= box;
						end
					end
					KIND_BODY: begin
						if (!body_seen_q || d2 < body_dist_q) begin
							body_seen_q <= 1'b1;
							body_dist_q <= d2;
							body_box_q  <= box;
						end
					end
					KIND_FINISH: begin
						head_seen_q <= 1'b0;
						body_seen_q <= 1'b0;
						head_dist_q <= '1;
						body_dist_q <= '1;
						head_box_q  <= '0;
						body_box_q  <= '0;
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && kind == KIND_FINISH) begin
			found_q   <= head_seen_q || body_seen_q;
			is_head_q <= head_seen_q;
			if (head_seen_q) begin
				sel_q <= head_box_q;
			end else if (body_seen_q) begin
				sel_q <= body_box_q;
			end else begin
				sel_q <= '0;
			end
		end
	end

	assign out_ch.valid     = out_valid_q;
	assign out_ch.found     = found_q;
	assign out_ch.is_head   = is_head_q;
	assign out_ch.sel_x     = sel_q[CLASS_BITS + 3*COORD_BITS +: COORD_BITS];
	assign out_ch.sel_y     = sel_q[CLASS_BITS + 2*COORD_BITS +: COORD_BITS];
	assign out_ch.sel_w     = sel_q[CLASS_BITS + COORD_BITS +: COORD_BITS];
	assign out_ch.sel_h     = sel_q[CLASS_BITS +: COORD_BITS];
	assign out_ch.sel_class = sel_q[CLASS_BITS-1:0];

endmodule

// ----- sv/nearest_box_to_center_select.sv -----
// Top level: nearest head/body box to screen centre, with configuration registers.
//
// Takes one box or finish transaction per cycle while the input is not stalled.
// A box passes a three-stage front end (aim-point multiply, centre differences,
// squares) into a four-entry queue; the back end pops one entry per cycle unless
// stalled and updates the head or body minimum. A finish goes through the front
// end and the queue to the result register, and only stalls the back end while an
// earlier result is not yet taken; the queue and front end fill and the input stalls.
module nearest_box_to_center_select import nbc_pkg::*; #(
	parameter int COORD_BITS = DEF_COORD_BITS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
	nbc_in_if.sink                   in_ch,
	nbc_out_if.source                out_ch
);

	localparam int DW         = (COORD_BITS + 1 > CENTER_BITS) ? COORD_BITS + 1 : CENTER_BITS;
	localparam int DIST_BITS  = 2 * DW + 1;
	localparam int ENTRY_BITS = 2 + DIST_BITS + 4 * COORD_BITS + CLASS_BITS;

	logic [SCREEN_BITS-1:0] screen_w_q, screen_h_q;
	logic [OFFSET_BITS-1:0] offset_q;
	nbc_cfg_t               cfg;

	logic                  q_push, q_ready, q_valid, q_pop;
	logic [ENTRY_BITS-1:0] q_wdata, q_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_w_q <= SCREEN_W_RST;
			screen_h_q <= SCREEN_H_RST;
			offset_q   <= OFFSET_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SCREEN_WIDTH:  screen_w_q <= cfg_wdata[SCREEN_BITS-1:0];
				REG_SCREEN_HEIGHT: screen_h_q <= cfg_wdata[SCREEN_BITS-1:0];
				REG_BODY_OFFSET:   offset_q   <= cfg_wdata[OFFSET_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign cfg.cx          = screen_w_q[SCREEN_BITS-1:1];
	assign cfg.cy          = screen_h_q[SCREEN_BITS-1:1];
	assign cfg.body_offset = offset_q;

	nbc_front #(
		.COORD_BITS (COORD_BITS),
		.DIST_BITS  (DIST_BITS),
		.ENTRY_BITS (ENTRY_BITS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.cfg     (cfg),
		.q_push  (q_push),
		.q_ready (q_ready),
		.q_data  (q_wdata)
	);

	nbc_fifo #(
		.WIDTH (ENTRY_BITS),
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_ready (q_ready),
		.push_data  (q_wdata),
		.pop_valid  (q_valid),
		.pop        (q_pop),
		.pop_data   (q_rdata)
	);

	nbc_back #(
		.COORD_BITS (COORD_BITS),
		.DIST_BITS  (DIST_BITS),
		.ENTRY_BITS (ENTRY_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_pop   (q_pop),
		.q_data  (q_rdata),
		.out_ch  (out_ch)
	);

endmodule
